[sv/tvp_pkg.sv]
// Package for the trapezoidal velocity profile generator.
// Holds payload types, the fixed-point format and the shared unit's operation codes.
// No dependencies.
`default_nettype none
package tvp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TIME_W    = 48;
   localparam int MIN_Q     = ((1 << FRAC_BITS) + 999) / 1000;

   localparam logic [1:0] ALU_MUL  = 2'd0;
   localparam logic [1:0] ALU_DIV  = 2'd1;
   localparam logic [1:0] ALU_SQRT = 2'd2;

   typedef struct packed {
      logic              command;
      logic signed [31:0] start_position;
      logic signed [31:0] target_position;
      logic [15:0]        tick_length;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] velocity;
      logic               done_res;
   } rsp_payload_type;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } alu_ctl_type;

endpackage
`default_nettype wire

[sv/trapezoidal_velocity_profile_top.sv]
// Top level of the trapezoidal velocity profile generator: sequencer and state.
// Depends on tvp_pkg and tvp_alu.
//
// Usage: an item on the req_ channel is either a plan (command 0) carrying the
// start and target positions, or a tick (command 1) carrying the tick length.
// A plan returns nothing; each tick returns one item on the rsp_ channel with the
// signed velocity at the current elapsed time and a done flag.
// The csr_ channel writes cruise speed, ramp times and epsilon by index; it is
// always ready and should only be used while the block is idle.
// All arithmetic runs on one shared bit-serial unit (one bit of a product or a
// quotient, or one root digit, per cycle).
// req_ready is high only while the sequencer is idle; one item is worked at a time.
// A finished tick result waits in the output register; if the receiver stalls
// while a later tick finishes, the sequencer holds that result until the slot frees.
// A plan may be accepted and worked while a result still waits.
// Synchronous reset clears the state, configuration and plan registers, so ticks report done.
`default_nettype none
module trapezoidal_velocity_profile_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire tvp_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output tvp_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [7:0]               csr_index,
   input  wire logic [31:0]              csr_data
);
   import tvp_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_AR   = 4'd1;
   localparam logic [3:0] S_DR   = 4'd2;
   localparam logic [3:0] S_M1   = 4'd3;
   localparam logic [3:0] S_M2   = 4'd4;
   localparam logic [3:0] S_CMP  = 4'd5;
   localparam logic [3:0] S_CE   = 4'd6;
   localparam logic [3:0] S_TOT  = 4'd7;
   localparam logic [3:0] S_Q    = 4'd8;
   localparam logic [3:0] S_SQ   = 4'd9;
   localparam logic [3:0] S_V    = 4'd10;
   localparam logic [3:0] S_AE   = 4'd11;
   localparam logic [3:0] S_TT   = 4'd12;
   localparam logic [3:0] S_TICK = 4'd13;
   localparam logic [3:0] S_EMIT = 4'd14;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_POS  = 2'd1;
   localparam logic [1:0] DIR_NEG  = 2'd3;

   localparam logic [7:0] REG_CRUISE = 8'd0;
   localparam logic [7:0] REG_RAMPUP = 8'd1;
   localparam logic [7:0] REG_RAMPDN = 8'd2;
   localparam logic [7:0] REG_EPS    = 8'd3;

   localparam logic [TIME_W-1:0] T_MAX = '1;

   // Saturate a 49-bit time sum to 48 bits.
   function automatic logic [TIME_W-1:0] sat48(input logic [TIME_W:0] v);
      return v[TIME_W] ? T_MAX : v[TIME_W-1:0];
   endfunction

   logic [3:0]        state_ff, state_in;
   logic [30:0]       cruise_ff, cruise_in;
   logic [31:0]       ramp_up_ff, ramp_up_in;
   logic [31:0]       ramp_dn_ff, ramp_dn_in;
   logic [30:0]       eps_ff, eps_in;
   logic [TIME_W-1:0] et_ff, et_in;
   logic [1:0]        dir_ff, dir_in;
   logic [TIME_W-1:0] ar_ff, ar_in;
   logic [TIME_W-1:0] dr_ff, dr_in;
   logic [31:0]       peak_ff, peak_in;
   logic [TIME_W-1:0] aend_ff, aend_in;
   logic [TIME_W-1:0] cend_ff, cend_in;
   logic [TIME_W-1:0] total_ff, total_in;
   logic [32:0]       dist_ff, dist_in;
   logic [TIME_W-1:0] tmp_ff, tmp_in;
   logic [15:0]       tick_ff, tick_in;
   logic              adv_ff, adv_in;
   logic              fin_ff, fin_in;
   logic              phase_ff, phase_in;
   logic [31:0]       vel_ff, vel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;
   alu_ctl_type       ctl_ff, ctl_in;
   logic [63:0]       opa_ff, opa_in;
   logic [63:0]       opb_ff, opb_in;

   logic [63:0] alu_result;
   logic        alu_ovf;
   logic        alu_done;

   // Clamped working copies of the configuration.
   logic [30:0] c_w;
   logic [31:0] ru_w;
   logic [31:0] rd_w;
   logic signed [32:0] diff_w;
   logic [32:0] absd_w;
   logic [TIME_W-1:0] prod_hi;
   logic [32:0] dleft;

   assign c_w  = (cruise_ff > 31'(MIN_Q)) ? cruise_ff : 31'(MIN_Q);
   assign ru_w = (ramp_up_ff > 32'(MIN_Q)) ? ramp_up_ff : 32'(MIN_Q);
   assign rd_w = (ramp_dn_ff > 32'(MIN_Q)) ? ramp_dn_ff : 32'(MIN_Q);
   assign diff_w = 33'(req_payload.target_position) - 33'(req_payload.start_position);
   assign absd_w = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
   assign prod_hi = alu_result[FRAC_BITS +: TIME_W];
   assign dleft = dist_ff - tmp_ff[32:0];

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   tvp_alu u_alu (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_ff),
      .opa      (opa_ff),
      .opb      (opb_ff),
      .result   (alu_result),
      .overflow (alu_ovf),
      .done     (alu_done)
   );

   always_comb begin
      state_in     = state_ff;
      cruise_in    = cruise_ff;
      ramp_up_in   = ramp_up_ff;
      ramp_dn_in   = ramp_dn_ff;
      eps_in       = eps_ff;
      et_in        = et_ff;
      dir_in       = dir_ff;
      ar_in        = ar_ff;
      dr_in        = dr_ff;
      peak_in      = peak_ff;
      aend_in      = aend_ff;
      cend_in      = cend_ff;
      total_in     = total_ff;
      dist_in      = dist_ff;
      tmp_in       = tmp_ff;
      tick_in      = tick_ff;
      adv_in       = adv_ff;
      fin_in       = fin_ff;
      phase_in     = phase_ff;
      vel_in       = vel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ctl_in       = '{start: 1'b0, op: ctl_ff.op};
      opa_in       = opa_ff;
      opb_in       = opb_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_CRUISE: cruise_in  = csr_data[30:0];
            REG_RAMPUP: ramp_up_in = csr_data;
            REG_RAMPDN: ramp_dn_in = csr_data;
            REG_EPS:    eps_in     = csr_data[30:0];
            default:    cruise_in  = cruise_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_payload.command) begin
                  et_in   = '0;
                  dist_in = absd_w;
                  if (absd_w < {2'b00, eps_ff}) begin
                     dir_in   = DIR_NONE;
                     ar_in    = '0;
                     dr_in    = '0;
                     peak_in  = '0;
                     aend_in  = '0;
                     cend_in  = '0;
                     total_in = '0;
                  end else begin
                     dir_in   = (diff_w > 0) ? DIR_POS : DIR_NEG;
                     ctl_in   = '{start: 1'b1, op: ALU_DIV};
                     opa_in   = {17'b0, c_w, 16'b0};
                     opb_in   = {32'b0, ru_w};
                     state_in = S_AR;
                  end
               end else begin
                  tick_in = req_payload.tick_length;
                  if (dir_ff == DIR_NONE || et_ff >= total_ff) begin
                     fin_in   = 1'b1;
                     adv_in   = 1'b0;
                     vel_in   = '0;
                     state_in = S_EMIT;
                  end else if (et_ff < aend_ff) begin
                     fin_in   = 1'b0;
                     phase_in = 1'b0;
                     ctl_in   = '{start: 1'b1, op: ALU_MUL};
                     opa_in   = {16'b0, ar_ff};
                     opb_in   = {16'b0, et_ff};
                     state_in = S_TICK;
                  end else if (et_ff < cend_ff) begin
                     fin_in   = 1'b0;
                     adv_in   = 1'b1;
                     vel_in   = peak_ff;
                     state_in = S_EMIT;
                  end else begin
                     fin_in   = 1'b0;
                     phase_in = 1'b1;
                     ctl_in   = '{start: 1'b1, op: ALU_MUL};
                     opa_in   = {16'b0, dr_ff};
                     opb_in   = {16'b0, et_ff - cend_ff};
                     state_in = S_TICK;
                  end
               end
            end
         end
         S_AR: begin
            if (alu_done) begin
               ar_in    = (alu_result == '0) ? TIME_W'(1) : alu_result[TIME_W-1:0];
               ctl_in   = '{start: 1'b1, op: ALU_DIV};
               opa_in   = {17'b0, c_w, 16'b0};
               opb_in   = {32'b0, rd_w};
               state_in = S_DR;
            end
         end
         S_DR: begin
            if (alu_done) begin
               dr_in    = (alu_result == '0) ? TIME_W'(1) : alu_result[TIME_W-1:0];
               ctl_in   = '{start: 1'b1, op: ALU_MUL};
               opa_in   = {33'b0, c_w};
               opb_in   = {32'b0, ru_w};
               state_in = S_M1;
            end
         end
         S_M1: begin
            if (alu_done) begin
               tmp_in   = {1'b0, alu_result[63:17]};
               ctl_in   = '{start: 1'b1, op: ALU_MUL};
               opa_in   = {33'b0, c_w};
               opb_in   = {32'b0, rd_w};
               state_in = S_M2;
            end
         end
         S_M2: begin
            // The minimum distance for a full trapezoid.
            if (alu_done) begin
               tmp_in   = tmp_ff + {1'b0, alu_result[63:17]};
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if ({15'b0, dist_ff} >= tmp_ff) begin
               peak_in  = {1'b0, c_w};
               aend_in  = {16'b0, ru_w};
               ctl_in   = '{start: 1'b1, op: ALU_DIV};
               opa_in   = {15'b0, dleft, 16'b0};
               opb_in   = {33'b0, c_w};
               state_in = S_CE;
            end else begin
               ctl_in   = '{start: 1'b1, op: ALU_DIV};
               opa_in   = {14'b0, dist_ff, 17'b0};
               opb_in   = {31'b0, 33'({1'b0, ru_w} + {1'b0, rd_w})};
               state_in = S_Q;
            end
         end
         S_CE: begin
            if (alu_done) begin
               cend_in  = sat48({17'b0, ru_w} + {1'b0, alu_result[TIME_W-1:0]});
               state_in = S_TOT;
            end
         end
         S_TOT: begin
            total_in = sat48({1'b0, cend_ff} + {17'b0, rd_w});
            state_in = S_IDLE;
         end
         S_Q: begin
            // Triangle: the peak is sqrt(q * c), with q capped at c.
            if (alu_done) begin
               ctl_in   = '{start: 1'b1, op: ALU_MUL};
               opa_in   = (alu_result > {33'b0, c_w}) ? {33'b0, c_w} : alu_result;
               opb_in   = {33'b0, c_w};
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (alu_done) begin
               ctl_in   = '{start: 1'b1, op: ALU_SQRT};
               opa_in   = alu_result;
               state_in = S_V;
            end
         end
         S_V: begin
            if (alu_done) begin
               peak_in  = (alu_result > {33'b0, c_w}) ? {1'b0, c_w} : alu_result[31:0];
               ctl_in   = '{start: 1'b1, op: ALU_DIV};
               opa_in   = {16'b0, ((alu_result > {33'b0, c_w}) ? {1'b0, c_w} :
                                   alu_result[31:0]), 16'b0};
               opb_in   = {16'b0, ar_ff};
               state_in = S_AE;
            end
         end
         S_AE: begin
            if (alu_done) begin
               aend_in  = (alu_result[63:TIME_W] != '0) ? T_MAX : alu_result[TIME_W-1:0];
               cend_in  = (alu_result[63:TIME_W] != '0) ? T_MAX : alu_result[TIME_W-1:0];
               ctl_in   = '{start: 1'b1, op: ALU_DIV};
               opa_in   = {16'b0, peak_ff, 16'b0};
               opb_in   = {16'b0, dr_ff};
               state_in = S_TT;
            end
         end
         S_TT: begin
            if (alu_done) begin
               total_in = sat48({1'b0, aend_ff} + {1'b0, alu_result[TIME_W-1:0]});
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            if (alu_done) begin
               adv_in = 1'b1;
               if (!phase_ff) begin
                  vel_in = (prod_hi > {16'b0, peak_ff}) ? peak_ff : prod_hi[31:0];
               end else begin
                  // A decrement too large for 64 bits brings the speed to zero.
                  vel_in = (alu_ovf || prod_hi >= {16'b0, peak_ff}) ? 32'd0 :
                           peak_ff - prod_hi[31:0];
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.velocity      = (dir_ff == DIR_NEG) ? -$signed(vel_ff) : $signed(vel_ff);
               rsp_in.done_res      = fin_ff;
               if (adv_ff) et_in    = sat48({1'b0, et_ff} + {33'b0, tick_ff});
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cruise_ff    <= '0;
         ramp_up_ff   <= '0;
         ramp_dn_ff   <= '0;
         eps_ff       <= '0;
         et_ff        <= '0;
         dir_ff       <= DIR_NONE;
         ar_ff        <= '0;
         dr_ff        <= '0;
         peak_ff      <= '0;
         aend_ff      <= '0;
         cend_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ctl_ff       <= '{start: 1'b0, op: ALU_MUL};
      end else begin
         state_ff     <= state_in;
         cruise_ff    <= cruise_in;
         ramp_up_ff   <= ramp_up_in;
         ramp_dn_ff   <= ramp_dn_in;
         eps_ff       <= eps_in;
         et_ff        <= et_in;
         dir_ff       <= dir_in;
         ar_ff        <= ar_in;
         dr_ff        <= dr_in;
         peak_ff      <= peak_in;
         aend_ff      <= aend_in;
         cend_ff      <= cend_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         ctl_ff       <= ctl_in;
      end
      dist_ff  <= dist_in;
      tmp_ff   <= tmp_in;
      tick_ff  <= tick_in;
      adv_ff   <= adv_in;
      fin_ff   <= fin_in;
      phase_ff <= phase_in;
      vel_ff   <= vel_in;
      rsp_ff   <= rsp_in;
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
   end

endmodule
`default_nettype wire

[sv/tvp_alu.sv]
// Shared radix-2 arithmetic unit: shift-add multiply, restoring divide, integer square root.
// Depends on tvp_pkg.
`default_nettype none
module tvp_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tvp_pkg::alu_ctl_type ctl,
   input  wire logic [63:0]        opa,
   input  wire logic [63:0]        opb,
   output logic [63:0]             result,
   output logic                    overflow,
   output logic                    done
);
   import tvp_pkg::*;

   logic [1:0]  op_ff, op_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [48:0] rem_ff, rem_in;
   logic        ovf_ff, ovf_in;
   logic        lost_ff, lost_in;
   logic [48:0] trial;
   logic [48:0] part;
   logic [64:0] sum;

   assign result   = acc_ff;
   assign overflow = ovf_ff;
   assign done     = done_ff;

   always_comb begin
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      ovf_in  = ovf_ff;
      lost_in = lost_ff;
      part    = '0;
      trial   = '0;
      sum     = '0;
      if (ctl.start) begin
         op_in   = ctl.op;
         busy_in = 1'b1;
         a_in    = opa;
         b_in    = opb;
         acc_in  = '0;
         rem_in  = '0;
         ovf_in  = 1'b0;
         lost_in = 1'b0;
         unique case (ctl.op)
            ALU_MUL:  cnt_in = 7'd48;
            ALU_DIV:  cnt_in = 7'd64;
            ALU_SQRT: cnt_in = 7'd32;
            default:  cnt_in = 7'd1;
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_MUL: begin
               // The product overflows 64 bits if an addition carries out or if a
               // partial product that has already lost high bits is added.
               sum = {1'b0, acc_ff} + {1'b0, a_ff};
               if (b_ff[0]) begin
                  acc_in = sum[63:0];
                  if (sum[64] || lost_ff) ovf_in = 1'b1;
               end
               lost_in = lost_ff | a_ff[63];
               a_in = {a_ff[62:0], 1'b0};
               b_in = {1'b0, b_ff[63:1]};
            end
            ALU_DIV: begin
               part  = {rem_ff[47:0], a_ff[63]};
               trial = b_ff[48:0];
               a_in  = {a_ff[62:0], 1'b0};
               if (part >= trial) begin
                  rem_in = part - trial;
                  acc_in = {acc_ff[62:0], 1'b1};
               end else begin
                  rem_in = part;
                  acc_in = {acc_ff[62:0], 1'b0};
               end
            end
            ALU_SQRT: begin
               part  = {rem_ff[46:0], a_ff[63:62]};
               trial = {acc_ff[46:0], 2'b01};
               a_in  = {a_ff[61:0], 2'b00};
               if (part >= trial) begin
                  rem_in = part - trial;
                  acc_in = {acc_ff[62:0], 1'b1};
               end else begin
                  rem_in = part;
                  acc_in = {acc_ff[62:0], 1'b0};
               end
            end
            default: acc_in = acc_ff;
         endcase
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      ovf_ff  <= ovf_in;
      lost_ff <= lost_in;
   end

endmodule
`default_nettype wire

[tb/sv/tvp_checker.sv]
`timescale 1ns / 1ps
// Checker for the trapezoidal velocity profile generator: it watches the channels,
// predicts each tick result and compares. Depends on tvp_pkg.
module tvp_checker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire tvp_pkg::req_payload_type req_payload,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire tvp_pkg::rsp_payload_type rsp_payload,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [7:0]               csr_index,
   input  wire logic [31:0]              csr_data,
   output int                            fail_count,
   output int                            pending_count
);
   import tvp_pkg::*;

   localparam logic [63:0] TIME_LIMIT = (64'd1 << TIME_W) - 64'd1;
   localparam logic [63:0] MIN_STEP   = 64'(MIN_Q);

   typedef enum logic [7:0] {
      REG_CRUISE = 8'd0, REG_RAMP_UP = 8'd1, REG_RAMP_DOWN = 8'd2, REG_EPSILON = 8'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0, DIR_POS = 2'd1, DIR_NEG = 2'd3
   } move_dir_type;

   logic [63:0] cruise, ramp_up, ramp_fall, eps_dist;
   logic [63:0] elapsed, accel, decel, accel_end, cruise_end, total, peak;
   move_dir_type dir;
   rsp_payload_type velocity_queue[$];

   assign pending_count = velocity_queue.size();

   function automatic logic [63:0] sat_time(input logic [63:0] v);
      return (v > TIME_LIMIT) ? TIME_LIMIT : v;
   endfunction

   function automatic logic [63:0] floor_at(input logic [63:0] v, input logic [63:0] m);
      return (v > m) ? v : m;
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic clear_move();
      dir = DIR_NONE;
      accel = 0; decel = 0; peak = 0;
      accel_end = 0; cruise_end = 0; total = 0;
   endtask

   task automatic plan_move(input logic signed [31:0] s, input logic signed [31:0] t);
      longint diff;
      logic [63:0] span, ru, rd, c, dmin, q, v;
      diff = longint'(t) - longint'(s);
      span = (diff < 0) ? -diff : diff;
      elapsed = 0;
      if (span < eps_dist) begin
         clear_move();
      end else begin
         dir = (diff > 0) ? DIR_POS : DIR_NEG;
         ru = floor_at(ramp_up, MIN_STEP);
         rd = floor_at(ramp_fall, MIN_STEP);
         c  = floor_at(cruise, MIN_STEP);
         accel = floor_at(sat_time((c << FRAC_BITS) / ru), 64'd1);
         decel = floor_at(sat_time((c << FRAC_BITS) / rd), 64'd1);
         dmin = ((c * ru) >> (FRAC_BITS + 1)) + ((c * rd) >> (FRAC_BITS + 1));
         if (span >= dmin) begin
            peak = c;
            accel_end = ru;
            cruise_end = sat_time(ru + ((span - dmin) << FRAC_BITS) / c);
            total = sat_time(cruise_end + rd);
         end else begin
            // Triangle: the peak is set by the distance, capped at cruise.
            q = ((span << 1) << FRAC_BITS) / (ru + rd);
            if (q > c) q = c;
            v = floor_sqrt(q * c);
            if (v > c) v = c;
            peak = v;
            accel_end = sat_time((v << FRAC_BITS) / accel);
            cruise_end = accel_end;
            total = sat_time(accel_end + (v << FRAC_BITS) / decel);
         end
      end
   endtask

   function automatic rsp_payload_type tick_velocity(input logic [15:0] len);
      rsp_payload_type r;
      logic [63:0] vel, td, dv;
      if (dir == DIR_NONE || elapsed >= total) begin
         r.velocity = 0;
         r.done_res = 1'b1;
         return r;
      end
      if (elapsed < accel_end) begin
         vel = (accel * elapsed) >> FRAC_BITS;
         if (vel > peak) vel = peak;
      end else if (elapsed < cruise_end) begin
         vel = peak;
      end else begin
         td = elapsed - cruise_end;
         if (td > 64'hFFFF_FFFF_FFFF_FFFF / decel) begin
            vel = 0;
         end else begin
            dv = (decel * td) >> FRAC_BITS;
            vel = (dv >= peak) ? 64'd0 : peak - dv;
         end
      end
      if (vel > 64'h7FFF_FFFF) vel = 64'h7FFF_FFFF;
      elapsed = sat_time(elapsed + 64'(len));
      r.velocity = (dir == DIR_NEG) ? -vel[31:0] : vel[31:0];
      r.done_res = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      int errs;
      errs = 0;
      if (reset) begin
         cruise = 0; ramp_up = 0; ramp_fall = 0; eps_dist = 0;
         elapsed = 0;
         clear_move();
         velocity_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CRUISE:    cruise    = {33'd0, csr_data[30:0]};
               REG_RAMP_UP:   ramp_up   = {32'd0, csr_data};
               REG_RAMP_DOWN: ramp_fall = {32'd0, csr_data};
               REG_EPSILON:   eps_dist  = {33'd0, csr_data[30:0]};
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (velocity_queue.size() == 0) begin
               $display("%0t: unexpected result, got velocity %0d done %0b",
                        $time, rsp_payload.velocity, rsp_payload.done_res);
               errs++;
            end else begin
               want = velocity_queue.pop_front();
               if (want.velocity !== rsp_payload.velocity) begin
                  $display("%0t: velocity expected %0d actual %0d",
                           $time, want.velocity, rsp_payload.velocity);
                  errs++;
               end
               if (want.done_res !== rsp_payload.done_res) begin
                  $display("%0t: done_res expected %0b actual %0b",
                           $time, want.done_res, rsp_payload.done_res);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_payload.command)
               velocity_queue.push_back(tick_velocity(req_payload.tick_length));
            else
               plan_move(req_payload.start_position, req_payload.target_position);
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the testbench for the trapezoidal velocity profile generator: clock, reset,
// stimulus and verdict. Depends on tvp_pkg, tvp_checker and the block itself.
module testbench;
   import tvp_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   // A plan gives no result, so the settling time also lets a plan in progress finish.
   localparam int SETTLE_CYCLES = 600;

   localparam logic [7:0] REG_CRUISE    = 8'd0;
   localparam logic [7:0] REG_RAMP_UP   = 8'd1;
   localparam logic [7:0] REG_RAMP_DOWN = 8'd2;
   localparam logic [7:0] REG_EPSILON   = 8'd3;
   localparam logic       CMD_PLAN      = 1'b0;
   localparam logic       CMD_TICK      = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0, csr_ready;
   logic [7:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   int fail_count, pending_count;
   int cycle_count = 0;
   int rsp_stall = 0;
   // When set, neither side inserts gaps, so back-to-back items get exercised.
   bit steady_flow = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   trapezoidal_velocity_profile_top uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   tvp_checker checker_i (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending_count
   );

   // The run is ended here if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // The receiver may stall after every item it takes, unless steady_flow is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_stall <= steady_flow ? 0 : $urandom_range(4);
         rsp_ready <= steady_flow || ($urandom_range(4) == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_profile(input logic [31:0] speed, input logic [31:0] up,
                              input logic [31:0] down, input logic [31:0] eps);
      write_reg(REG_CRUISE, speed);
      write_reg(REG_RAMP_UP, up);
      write_reg(REG_RAMP_DOWN, down);
      write_reg(REG_EPSILON, eps);
   endtask

   // Valid is held, with the payload fixed, until the item is taken.
   task automatic send_item(input req_payload_type p);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_plan(input logic [31:0] from_pos, input logic [31:0] to_pos);
      req_payload_type p;
      p.command = CMD_PLAN;
      p.start_position = from_pos;
      p.target_position = to_pos;
      p.tick_length = 16'($urandom);
      send_item(p);
   endtask

   task automatic send_tick(input logic [15:0] len);
      req_payload_type p;
      p.command = CMD_TICK;
      p.start_position = $urandom;
      p.target_position = $urandom;
      p.tick_length = len;
      send_item(p);
   endtask

   // Lets every result drain and any plan in progress finish before a register write.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int n_items, ticks, origin_mm;
      logic [31:0] from_pos;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A tick before any plan reports done.
      send_tick(16'd1000);
      drain();

      // Directed part: 10 mm/s, half-second ramps, a 100 mm move forward.
      set_profile(32'd10 << 16, 32'd32768, 32'd32768, 32'd0);
      send_plan(32'd0, 32'd100 << 16);
      repeat (4) send_tick(16'hFFFF);
      send_tick(16'd0);
      // Short move backward, so the profile is a triangle.
      send_plan(32'd5 << 16, 32'd4 << 16);
      repeat (4) send_tick(16'd16384);
      // Zero distance with zero epsilon finishes on the first tick.
      send_plan(32'h1234_5678, 32'h1234_5678);
      send_tick(16'd100);
      // Full range of positions in both directions.
      send_plan(32'h8000_0000, 32'h7FFF_FFFF);
      send_tick(16'hFFFF);
      send_plan(32'h7FFF_FFFF, 32'h8000_0000);
      send_tick(16'hFFFF);
      drain();

      // Distances below epsilon count as already there; unknown indexes are ignored.
      set_profile(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1 << 16);
      write_reg(8'd4, 32'hFFFF_FFFF);
      write_reg(8'd255, 32'd0);
      send_plan(32'd0, 32'd100);
      send_tick(16'd500);
      send_plan(32'd0, 32'd1 << 20);
      repeat (3) send_tick(16'd1);
      drain();

      // Slowest extremes: minimum speed, longest ramps, largest epsilon.
      set_profile(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_plan(32'h8000_0000, 32'h7FFF_FFFF);
      send_tick(16'hFFFF);
      drain();

      // Random part: phases of random settings, mostly realistic moves.
      n_items = 0;
      for (int phase = 0; n_items < 900; phase++) begin
         steady_flow = (phase % 4 == 3);
         if (phase % 5 == 4) begin
            set_profile($urandom, $urandom, $urandom, $urandom);
         end else begin
            set_profile($urandom_range(200 << 16, 1 << 12), $urandom_range(3 << 16, 0),
                        $urandom_range(3 << 16, 0), $urandom_range(1 << 16, 0));
         end
         for (int k = 0; k < 8; k++) begin
            if ($urandom_range(9) == 0) begin
               send_plan($urandom, $urandom);
               n_items++;
            end else begin
               origin_mm = $urandom_range(2000) - 1000;
               from_pos = 32'(origin_mm) << 16;
               send_plan(from_pos, from_pos + ($urandom_range(1 << 24) - (1 << 23)));
               ticks = $urandom_range(30, 3);
               for (int j = 0; j < ticks; j++) begin
                  send_tick(($urandom_range(7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(20000)));
               end
               n_items += ticks + 1;
            end
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
sv/tvp_pkg.sv
sv/tvp_alu.sv
sv/trapezoidal_velocity_profile_top.sv
tb/sv/tvp_checker.sv
tb/sv/testbench.sv
